// File: hw/rtl/edf_pkg.sv
package edf_pkg;

	localparam int MAX_TASK_SLOTS = 8;
	localparam int SLOT_W  = (MAX_TASK_SLOTS > 1) ? $clog2(MAX_TASK_SLOTS) : 1;
	localparam int COUNT_W = $clog2(MAX_TASK_SLOTS + 1);

	localparam int PERIOD_W = 8;
	localparam int EXEC_W   = 8;
	localparam int CEIL_W   = 9;
	localparam int GRANT_W  = 3;
	localparam int MISS_W   = 8;
	localparam int TICK_W   = 16;

	localparam logic [CEIL_W-1:0] CEIL_RESET = 9'd256;

	typedef enum logic {
		MODE_TICK = 1'b0,
		MODE_ADD  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_GRANT,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] period;
		logic [PERIOD_W-1:0] phase;
		logic                done;
		logic                fresh;
		logic [CEIL_W-1:0]   ceiling;
		logic [PERIOD_W-1:0] best_rem;
		logic                found;
	} slot_in_t;

	typedef struct packed {
		logic                miss;
		logic                done_next;
		logic                take;
		logic [PERIOD_W-1:0] rem;
		logic [PERIOD_W-1:0] phase_next;
	} slot_eval_t;

endpackage

// File: hw/rtl/edf_if.sv
interface edf_req_if;
	logic                          valid;
	logic                          ready;
	logic                          mode;
	logic [edf_pkg::PERIOD_W-1:0]  new_period;
	logic [edf_pkg::EXEC_W-1:0]    new_exec_length;
	modport source (output valid, mode, new_period, new_exec_length, input ready);
	modport sink   (input valid, mode, new_period, new_exec_length, output ready);
endinterface

interface edf_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          grant_valid;
	logic [edf_pkg::GRANT_W-1:0]   granted_task;
	logic                          task_completed;
	logic [edf_pkg::MISS_W-1:0]    miss_mask;
	logic                          add_accepted;
	logic                          table_full;
	logic [edf_pkg::TICK_W-1:0]    tick_time;
	modport source (output valid, grant_valid, granted_task, task_completed, miss_mask,
		add_accepted, table_full, tick_time, input ready);
	modport sink   (input valid, grant_valid, granted_task, task_completed, miss_mask,
		add_accepted, table_full, tick_time, output ready);
endinterface

interface edf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [edf_pkg::CEIL_W-1:0]    data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

// File: hw/rtl/edf_slot_unit.sv
module edf_slot_unit (
	input  edf_pkg::slot_in_t   slot,
	output edf_pkg::slot_eval_t eval
);

	logic                          boundary;
	logic [edf_pkg::PERIOD_W:0]    phase_inc;

	always_comb begin
		boundary       = (slot.phase == '0) && !slot.fresh;
		eval.miss      = boundary && !slot.done;
		eval.done_next = slot.done && !boundary;
		eval.rem       = slot.period - slot.phase;
		eval.take      = !eval.done_next
			&& ({1'b0, eval.rem} < slot.ceiling)
			&& (!slot.found || (eval.rem < slot.best_rem));
		phase_inc      = {1'b0, slot.phase} + 1'b1;
		if (phase_inc >= {1'b0, slot.period}) begin
			eval.phase_next = '0;
		end else begin
			eval.phase_next = phase_inc[edf_pkg::PERIOD_W-1:0];
		end
	end

endmodule

// File: hw/rtl/edf_periodic_task_scheduler.sv
// Channel | Dir | Payload                                     | Transaction
// req     | in  | mode, new_period, new_exec_length          | valid & ready
// rsp     | out | grant_valid, granted_task, task_completed, | valid & ready
//         |     | miss_mask, add_accepted, table_full,       |
//         |     | tick_time                                   |
// cfg     | in  | data (deadline_ceiling)                     | valid & ready
//
// Add item: goes straight from idle to emit, with no scan. Tick item: one slot
// per cycle passes through the shared slot unit (none if no task), then grant.
// req.ready is high only while idle; a pending result in the output register
// does not block the next accept, only its own emit.
// arst_n clears control state, task count, run counts and flags; ceiling = 256.
module edf_periodic_task_scheduler (
	input  logic            clk,
	input  logic            arst_n,
	edf_req_if.sink         req,
	edf_rsp_if.source       rsp,
	edf_cfg_if.sink         cfg
);

	localparam int NS = edf_pkg::MAX_TASK_SLOTS;
	localparam int SW = edf_pkg::SLOT_W;
	localparam int CW = edf_pkg::COUNT_W;

	localparam logic [edf_pkg::PERIOD_W-1:0] PERIOD_ONE = edf_pkg::PERIOD_W'(1);
	localparam logic [edf_pkg::EXEC_W-1:0]   EXEC_ONE   = edf_pkg::EXEC_W'(1);

	edf_pkg::state_t state_q, state_d;

	logic [edf_pkg::CEIL_W-1:0]   ceiling_q;
	logic [CW-1:0]                count_q;
	logic [edf_pkg::TICK_W-1:0]   tick_q;

	logic [edf_pkg::PERIOD_W-1:0] period_q [NS];
	logic [edf_pkg::EXEC_W-1:0]   exec_q   [NS];
	logic [edf_pkg::PERIOD_W-1:0] phase_q  [NS];
	logic [edf_pkg::EXEC_W-1:0]   run_q    [NS];
	logic [NS-1:0]                done_q;
	logic [NS-1:0]                fresh_q;

	logic [SW-1:0]                idx_q;
	logic [SW-1:0]                best_q;
	logic [edf_pkg::PERIOD_W-1:0] best_rem_q;
	logic                         found_q;

	logic                         r_grant_q;
	logic                         r_done_q;
	logic [edf_pkg::MISS_W-1:0]   r_miss_q;
	logic                         r_add_q;
	logic                         r_full_q;
	logic [edf_pkg::TICK_W-1:0]   r_tick_q;

	logic                         out_valid_q;
	logic                         out_grant_q;
	logic [edf_pkg::GRANT_W-1:0]  out_task_q;
	logic                         out_done_q;
	logic [edf_pkg::MISS_W-1:0]   out_miss_q;
	logic                         out_add_q;
	logic                         out_full_q;
	logic [edf_pkg::TICK_W-1:0]   out_tick_q;

	edf_pkg::slot_in_t            slot;
	edf_pkg::slot_eval_t          eval;

	logic                         accept;
	logic                         emit;
	logic                         room;
	logic                         last_slot;
	logic [SW-1:0]                add_slot;
	logic [edf_pkg::EXEC_W-1:0]   run_inc;

	assign room      = (count_q < CW'(NS));
	assign add_slot  = count_q[SW-1:0];
	assign last_slot = ((CW'(idx_q) + 1'b1) == count_q);
	assign run_inc   = run_q[best_q] + 1'b1;

	assign slot.period   = period_q[idx_q];
	assign slot.phase    = phase_q[idx_q];
	assign slot.done     = done_q[idx_q];
	assign slot.fresh    = fresh_q[idx_q];
	assign slot.ceiling  = ceiling_q;
	assign slot.best_rem = best_rem_q;
	assign slot.found    = found_q;

	edf_slot_unit u_slot (
		.slot (slot),
		.eval (eval)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= edf_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		accept    = 1'b0;
		emit      = 1'b0;
		unique case (state_q)
			edf_pkg::S_IDLE: begin
				req.ready = 1'b1;
				accept    = req.valid;
				if (req.valid) begin
					if (req.mode == edf_pkg::MODE_ADD) begin
						state_d = edf_pkg::S_EMIT;
					end else if (count_q == '0) begin
						state_d = edf_pkg::S_GRANT;
					end else begin
						state_d = edf_pkg::S_SCAN;
					end
				end
			end
			edf_pkg::S_SCAN: begin
				if (last_slot) begin
					state_d = edf_pkg::S_GRANT;
				end
			end
			edf_pkg::S_GRANT: begin
				state_d = edf_pkg::S_EMIT;
			end
			edf_pkg::S_EMIT: begin
				if (!out_valid_q || rsp.ready) begin
					emit    = 1'b1;
					state_d = edf_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = edf_pkg::S_IDLE;
			end
		endcase
	end

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ceiling_q <= edf_pkg::CEIL_RESET;
		end else if (cfg.valid) begin
			ceiling_q <= cfg.data;
		end
	end

	// control state and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			tick_q  <= '0;
			done_q  <= '0;
			fresh_q <= '0;
			for (int i = 0; i < NS; i++) begin
				run_q[i] <= '0;
			end
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			if (accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if (req.mode == edf_pkg::MODE_ADD && room) begin
					count_q           <= count_q + 1'b1;
					run_q[add_slot]   <= '0;
					done_q[add_slot]  <= 1'b0;
					fresh_q[add_slot] <= 1'b1;
				end
			end
			if (state_q == edf_pkg::S_SCAN) begin
				done_q[idx_q]  <= eval.done_next;
				fresh_q[idx_q] <= 1'b0;
				if (eval.take) begin
					found_q <= 1'b1;
				end
				if (!last_slot) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (state_q == edf_pkg::S_GRANT) begin
				tick_q <= tick_q + 1'b1;
				if (found_q) begin
					if (run_inc == exec_q[best_q]) begin
						run_q[best_q]  <= '0;
						done_q[best_q] <= 1'b1;
					end else begin
						run_q[best_q] <= run_inc;
					end
				end
			end
		end
	end

	// task parameters, scan bookkeeping and result
	always_ff @(posedge clk) begin
		if (accept) begin
			r_grant_q <= 1'b0;
			r_done_q  <= 1'b0;
			r_miss_q  <= '0;
			r_tick_q  <= tick_q;
			r_add_q   <= (req.mode == edf_pkg::MODE_ADD) && room;
			best_q    <= '0;
			if (req.mode == edf_pkg::MODE_ADD && room) begin
				period_q[add_slot] <= (req.new_period == '0) ? PERIOD_ONE : req.new_period;
				exec_q[add_slot]   <= (req.new_exec_length == '0) ? EXEC_ONE
					: req.new_exec_length;
				phase_q[add_slot]  <= '0;
				r_full_q           <= ((count_q + 1'b1) >= CW'(NS));
			end else begin
				r_full_q <= !room;
			end
		end
		if (state_q == edf_pkg::S_SCAN) begin
			phase_q[idx_q] <= eval.phase_next;
			if (eval.miss && (int'(idx_q) < edf_pkg::MISS_W)) begin
				r_miss_q <= r_miss_q | (edf_pkg::MISS_W'(1) << idx_q);
			end
			if (eval.take) begin
				best_q     <= idx_q;
				best_rem_q <= eval.rem;
			end
		end
		if (state_q == edf_pkg::S_GRANT) begin
			r_grant_q <= found_q;
			r_done_q  <= found_q && (run_inc == exec_q[best_q]);
			r_full_q  <= !room;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_grant_q <= r_grant_q;
			out_task_q  <= r_grant_q ? edf_pkg::GRANT_W'(best_q) : '0;
			out_done_q  <= r_done_q;
			out_miss_q  <= r_miss_q;
			out_add_q   <= r_add_q;
			out_full_q  <= r_full_q;
			out_tick_q  <= r_tick_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.grant_valid    = out_grant_q;
	assign rsp.granted_task   = out_task_q;
	assign rsp.task_completed = out_done_q;
	assign rsp.miss_mask      = out_miss_q;
	assign rsp.add_accepted   = out_add_q;
	assign rsp.table_full     = out_full_q;
	assign rsp.tick_time      = out_tick_q;

endmodule

// File: hw/rtl/edf_checker.sv
module edf_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          req_valid,
	input logic                          req_ready,
	input logic                          rsp_valid,
	input logic                          rsp_ready,
	input logic                          grant_valid,
	input logic [edf_pkg::GRANT_W-1:0]   granted_task,
	input logic                          task_completed,
	input logic [edf_pkg::MISS_W-1:0]    miss_mask,
	input logic                          add_accepted,
	input logic [edf_pkg::TICK_W-1:0]    tick_time
);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("ready high right after an accepted transaction");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(tick_time)
			&& $stable(granted_task) && $stable(miss_mask))
		else $error("stalled result changed");

	a_add_no_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && add_accepted |-> !grant_valid && miss_mask == '0)
		else $error("add result carries tick fields");

	a_complete_granted: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && task_completed |-> grant_valid)
		else $error("completion without grant");

endmodule

bind edf_periodic_task_scheduler edf_checker u_edf_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.grant_valid    (rsp.grant_valid),
	.granted_task   (rsp.granted_task),
	.task_completed (rsp.task_completed),
	.miss_mask      (rsp.miss_mask),
	.add_accepted   (rsp.add_accepted),
	.tick_time      (rsp.tick_time)
);
